// File: rtl/core/slmb_pkg.sv
// Shared types, constants and helpers of the sliding local map box.
`timescale 1ns / 1ps

package slmb_pkg;

	localparam int unsigned POS_W  = 32;
	localparam int unsigned CFG_W  = 31;
	localparam int unsigned MR_W   = 13;
	localparam int unsigned THR_W  = 44;
	localparam int unsigned THR8_W = 36;
	localparam int unsigned MV_W   = 34;
	localparam int unsigned SUM_W  = 36;
	localparam int unsigned NUM_W  = 52;
	localparam int unsigned QUO_W  = 40;
	localparam int unsigned QA_W   = 41;
	localparam int unsigned HALF_W = 20;
	localparam int unsigned PP_W   = 40;
	localparam int unsigned PROD_W = 82;
	localparam int unsigned NAXES  = 3;

	localparam logic [1:0] CFG_CUBE_SIDE    = 2'd0;
	localparam logic [1:0] CFG_DETECT_RANGE = 2'd1;
	localparam logic [1:0] CFG_MOVE_RATIO   = 2'd2;

	localparam logic [CFG_W-1:0] CUBE_SIDE_RST    = 31'd65536000;
	localparam logic [CFG_W-1:0] DETECT_RANGE_RST = 31'd19660800;
	localparam logic [MR_W-1:0]  MOVE_RATIO_RST   = 13'd384;

	// Halves of ceil(2^42 / 5); exact for every 40-bit dividend.
	localparam logic [HALF_W-1:0] RECIP5_HI = 20'hCCCCC;
	localparam logic [HALF_W-1:0] RECIP5_LO = 20'hCCCCD;

	localparam logic signed [NUM_W-1:0] NUM_OFFSET = 52'sh2_8000_0000_0A00;
	localparam logic signed [QA_W-1:0]  QA_BIAS    = 41'sd137438953472;
	localparam logic signed [QA_W-1:0]  MV_MAX     = 41'sd8589934591;
	localparam logic signed [QA_W-1:0]  MV_MIN     = -41'sd8589934592;

	localparam logic signed [SUM_W-1:0] SAT_MAX = 36'sd2147483647;
	localparam logic signed [SUM_W-1:0] SAT_MIN = -36'sd2147483648;

	typedef enum logic [2:0] {
		DV_IDLE,
		DV_MUL,
		DV_SUB,
		DV_NUM,
		DV_PP,
		DV_ACC,
		DV_FIN
	} dv_state_t;

	typedef struct packed {
		logic                    move;
		logic                    down;
		logic signed [POS_W-1:0] new_lo;
		logic signed [POS_W-1:0] new_hi;
		logic signed [POS_W-1:0] rm_val;
	} lane_res_t;

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = $signed(v[POS_W-1:0]);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/sliding_local_map_box.sv
// Top level of the sliding local map box.
//
// Each input item is a sensor position (pos_x, pos_y, pos_z). The block keeps an
// axis-aligned local map cube around the sensor; the first item centers it.
// An item yields zero to three removal boxes (kind 1, one per shifted axis,
// in x, y, z order) and then the current box (kind 0) with last set.
// Both channels use valid and stall; a result is taken when out_valid is high
// and out_stall is low. Registers are written through cfg_we, cfg_index and
// cfg_data, by the user only while the block is idle; the block does not enforce it.
// The first result of an item comes from the input register and then the merge
// stage's registers. Three combinational lanes test all axes together, and the
// merge stage sends one result per cycle while out_stall is low. A new item is
// taken while results are still going out. After reset, and after every register
// write, the input is stalled while the sequencer steps through its MUL, SUB, NUM,
// PP, ACC and FIN states to derive the threshold and move distance; the divide by
// five is a reciprocal multiply over the PP and ACC states. Reset clears the box
// and the registers go to their reset values. A stalled result holds and backs
// up into the input.
`timescale 1ns / 1ps

module sliding_local_map_box (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [slmb_pkg::POS_W-1:0]   pos_x,
	input  logic signed [slmb_pkg::POS_W-1:0]   pos_y,
	input  logic signed [slmb_pkg::POS_W-1:0]   pos_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                kind,
	output logic signed [slmb_pkg::POS_W-1:0]   min_x,
	output logic signed [slmb_pkg::POS_W-1:0]   min_y,
	output logic signed [slmb_pkg::POS_W-1:0]   min_z,
	output logic signed [slmb_pkg::POS_W-1:0]   max_x,
	output logic signed [slmb_pkg::POS_W-1:0]   max_y,
	output logic signed [slmb_pkg::POS_W-1:0]   max_z,
	output logic                                last,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [slmb_pkg::CFG_W-1:0]          cfg_data
);

	logic [slmb_pkg::CFG_W-1:0]          cube_side_q;
	logic [slmb_pkg::CFG_W-1:0]          detect_range_q;
	logic [slmb_pkg::MR_W-1:0]           move_ratio_q;

	logic signed [slmb_pkg::POS_W-1:0]   box_lo_q [slmb_pkg::NAXES];
	logic signed [slmb_pkg::POS_W-1:0]   box_hi_q [slmb_pkg::NAXES];
	logic                                ready_q;

	logic                                valid_s1;
	logic signed [slmb_pkg::POS_W-1:0]   pos_s1 [slmb_pkg::NAXES];

	logic                                busy;
	logic [slmb_pkg::THR8_W-1:0]         thr8;
	logic signed [slmb_pkg::MV_W-1:0]    move_dist;
	slmb_pkg::lane_res_t                 res [slmb_pkg::NAXES];
	logic                                can_load;
	logic                                load;
	logic                                accept;

	assign load     = valid_s1 && can_load;
	assign in_stall = busy || (valid_s1 && !can_load);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cube_side_q    <= slmb_pkg::CUBE_SIDE_RST;
			detect_range_q <= slmb_pkg::DETECT_RANGE_RST;
			move_ratio_q   <= slmb_pkg::MOVE_RATIO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slmb_pkg::CFG_CUBE_SIDE:    cube_side_q    <= cfg_data;
				slmb_pkg::CFG_DETECT_RANGE: detect_range_q <= cfg_data;
				slmb_pkg::CFG_MOVE_RATIO:   move_ratio_q   <= cfg_data[slmb_pkg::MR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < slmb_pkg::NAXES; i++) begin
				pos_s1[i] <= '0;
			end
		end else if (accept) begin
			valid_s1  <= 1'b1;
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			for (int i = 0; i < slmb_pkg::NAXES; i++) begin
				box_lo_q[i] <= '0;
				box_hi_q[i] <= '0;
			end
		end else if (load) begin
			ready_q <= 1'b1;
			for (int i = 0; i < slmb_pkg::NAXES; i++) begin
				box_lo_q[i] <= res[i].new_lo;
				box_hi_q[i] <= res[i].new_hi;
			end
		end
	end

	slmb_derive u_derive (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (cfg_we),
		.cube_side    (cube_side_q),
		.detect_range (detect_range_q),
		.move_ratio   (move_ratio_q),
		.busy         (busy),
		.thr8         (thr8),
		.move_dist    (move_dist)
	);

	for (genvar g = 0; g < slmb_pkg::NAXES; g++) begin : g_lane
		slmb_lane u_lane (
			.first     (!ready_q),
			.pos       (pos_s1[g]),
			.lo        (box_lo_q[g]),
			.hi        (box_hi_q[g]),
			.thr8      (thr8),
			.move_dist (move_dist),
			.half      (cube_side_q[slmb_pkg::CFG_W-1:1]),
			.res       (res[g])
		);
	end

	slmb_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.old_lo    (box_lo_q),
		.old_hi    (box_hi_q),
		.res       (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.min_x     (min_x),
		.min_y     (min_y),
		.min_z     (min_z),
		.max_x     (max_x),
		.max_y     (max_y),
		.max_z     (max_z),
		.last      (last)
	);

endmodule

// File: rtl/core/slmb_derive.sv
// Sequencer that derives the edge threshold and move distance from the registers.
`timescale 1ns / 1ps

module slmb_derive (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  logic [slmb_pkg::CFG_W-1:0]          cube_side,
	input  logic [slmb_pkg::CFG_W-1:0]          detect_range,
	input  logic [slmb_pkg::MR_W-1:0]           move_ratio,
	output logic                                busy,
	output logic [slmb_pkg::THR8_W-1:0]         thr8,
	output logic signed [slmb_pkg::MV_W-1:0]    move_dist
);

	slmb_pkg::dv_state_t state_q, state_d;

	logic [slmb_pkg::THR_W-1:0]           thr_q;
	logic signed [45:0]                   b_q;
	logic signed [46:0]                   d_q;
	logic signed [37:0]                   qb_q;
	logic [slmb_pkg::QUO_W-1:0]           n_q;
	logic [slmb_pkg::PP_W-1:0]            pp_ll_q;
	logic [slmb_pkg::PP_W-1:0]            pp_lh_q;
	logic [slmb_pkg::PP_W-1:0]            pp_hl_q;
	logic [slmb_pkg::PP_W-1:0]            pp_hh_q;
	logic [slmb_pkg::THR8_W-1:0]          thr8_q;
	logic signed [slmb_pkg::MV_W-1:0]     mv_q;

	logic [slmb_pkg::THR_W-1:0]           thr_prod;
	logic signed [13:0]                   mr_off;
	logic signed [31:0]                   dr_s;
	logic signed [45:0]                   b_prod;
	logic signed [45:0]                   b_sum;
	logic signed [46:0]                   d_calc;
	logic signed [slmb_pkg::NUM_W-1:0]    d_ext;
	logic signed [slmb_pkg::NUM_W-1:0]    num_calc;
	logic [slmb_pkg::HALF_W-1:0]          n_lo;
	logic [slmb_pkg::HALF_W-1:0]          n_hi;
	logic [slmb_pkg::PP_W-1:0]            pp_ll;
	logic [slmb_pkg::PP_W-1:0]            pp_lh;
	logic [slmb_pkg::PP_W-1:0]            pp_hl;
	logic [slmb_pkg::PP_W-1:0]            pp_hh;
	logic [slmb_pkg::PP_W:0]              pp_mid;
	logic [slmb_pkg::PROD_W-1:0]          prod_sum;
	logic signed [slmb_pkg::QA_W-1:0]     qa;
	logic signed [slmb_pkg::QA_W-1:0]     qb_ext;
	logic signed [slmb_pkg::QA_W-1:0]     m_big;
	logic signed [slmb_pkg::QA_W-1:0]     m_clamp;

	assign thr_prod = 44'(detect_range) * 44'(move_ratio);
	assign mr_off   = $signed({1'b0, move_ratio}) - 14'sd256;
	assign dr_s     = $signed({1'b0, detect_range});
	assign b_prod   = 46'(dr_s) * 46'(mr_off);
	assign b_sum    = b_q + 46'sd128;
	assign d_calc   = $signed({8'b0, cube_side, 8'b0}) - $signed({2'b0, thr_q, 1'b0});
	assign d_ext    = 52'(d_q);
	assign num_calc = (d_ext <<< 3) + d_ext + slmb_pkg::NUM_OFFSET;

	// The divide by five is a multiply by the reciprocal, done on 20-bit halves.
	assign n_lo     = n_q[slmb_pkg::HALF_W-1:0];
	assign n_hi     = n_q[slmb_pkg::QUO_W-1:slmb_pkg::HALF_W];
	assign pp_ll    = 40'(n_lo) * 40'(slmb_pkg::RECIP5_LO);
	assign pp_lh    = 40'(n_lo) * 40'(slmb_pkg::RECIP5_HI);
	assign pp_hl    = 40'(n_hi) * 40'(slmb_pkg::RECIP5_LO);
	assign pp_hh    = 40'(n_hi) * 40'(slmb_pkg::RECIP5_HI);
	assign pp_mid   = 41'(pp_lh_q) + 41'(pp_hl_q);
	assign prod_sum = {2'b0, pp_hh_q, 40'b0} + {21'b0, pp_mid, 20'b0} + {42'b0, pp_ll_q};

	assign qa       = $signed({1'b0, n_q}) - slmb_pkg::QA_BIAS;
	assign qb_ext   = 41'(qb_q);
	assign m_big    = (qa > qb_ext) ? qa : qb_ext;

	always_comb begin
		if (m_big > slmb_pkg::MV_MAX) begin
			m_clamp = slmb_pkg::MV_MAX;
		end else if (m_big < slmb_pkg::MV_MIN) begin
			m_clamp = slmb_pkg::MV_MIN;
		end else begin
			m_clamp = m_big;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slmb_pkg::DV_IDLE: state_d = slmb_pkg::DV_IDLE;
			slmb_pkg::DV_MUL:  state_d = slmb_pkg::DV_SUB;
			slmb_pkg::DV_SUB:  state_d = slmb_pkg::DV_NUM;
			slmb_pkg::DV_NUM:  state_d = slmb_pkg::DV_PP;
			slmb_pkg::DV_PP:   state_d = slmb_pkg::DV_ACC;
			slmb_pkg::DV_ACC:  state_d = slmb_pkg::DV_FIN;
			slmb_pkg::DV_FIN:  state_d = slmb_pkg::DV_IDLE;
			default:           state_d = slmb_pkg::DV_IDLE;
		endcase
		if (restart) begin
			state_d = slmb_pkg::DV_MUL;
		end
	end

	always_comb begin
		busy = (state_q != slmb_pkg::DV_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slmb_pkg::DV_MUL;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			b_q     <= '0;
			d_q     <= '0;
			qb_q    <= '0;
			n_q     <= '0;
			pp_ll_q <= '0;
			pp_lh_q <= '0;
			pp_hl_q <= '0;
			pp_hh_q <= '0;
			thr8_q  <= '0;
			mv_q    <= '0;
		end else begin
			unique case (state_q)
				slmb_pkg::DV_MUL: begin
					thr_q <= thr_prod;
					b_q   <= b_prod;
				end
				slmb_pkg::DV_SUB: begin
					d_q  <= d_calc;
					qb_q <= $signed(b_sum[45:8]);
				end
				slmb_pkg::DV_NUM: begin
					n_q <= num_calc[49:10];
				end
				slmb_pkg::DV_PP: begin
					pp_ll_q <= pp_ll;
					pp_lh_q <= pp_lh;
					pp_hl_q <= pp_hl;
					pp_hh_q <= pp_hh;
				end
				slmb_pkg::DV_ACC: begin
					n_q <= prod_sum[slmb_pkg::PROD_W-1:42];
				end
				slmb_pkg::DV_FIN: begin
					thr8_q <= thr_q[slmb_pkg::THR_W-1:8];
					mv_q   <= m_clamp[slmb_pkg::MV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign thr8      = thr8_q;
	assign move_dist = mv_q;

endmodule

// File: rtl/core/slmb_lane.sv
// Per-axis lane: edge test, box shift and removal face for one axis.
`timescale 1ns / 1ps

module slmb_lane (
	input  logic                                first,
	input  logic signed [slmb_pkg::POS_W-1:0]   pos,
	input  logic signed [slmb_pkg::POS_W-1:0]   lo,
	input  logic signed [slmb_pkg::POS_W-1:0]   hi,
	input  logic [slmb_pkg::THR8_W-1:0]         thr8,
	input  logic signed [slmb_pkg::MV_W-1:0]    move_dist,
	input  logic [slmb_pkg::CFG_W-2:0]          half,
	output slmb_pkg::lane_res_t                 res
);

	logic signed [32:0]                   d_lo;
	logic signed [32:0]                   d_hi;
	logic [32:0]                          a_lo;
	logic [32:0]                          a_hi;
	logic                                 near_lo;
	logic                                 near_hi;
	logic signed [slmb_pkg::SUM_W-1:0]    mv_e;
	logic signed [slmb_pkg::SUM_W-1:0]    half_e;
	logic signed [slmb_pkg::POS_W-1:0]    lo_dn;
	logic signed [slmb_pkg::POS_W-1:0]    hi_dn;
	logic signed [slmb_pkg::POS_W-1:0]    lo_up;
	logic signed [slmb_pkg::POS_W-1:0]    hi_up;
	logic signed [slmb_pkg::POS_W-1:0]    p_lo;
	logic signed [slmb_pkg::POS_W-1:0]    p_hi;

	assign d_lo    = 33'(pos) - 33'(lo);
	assign d_hi    = 33'(pos) - 33'(hi);
	assign a_lo    = d_lo[32] ? 33'(-d_lo) : 33'(d_lo);
	assign a_hi    = d_hi[32] ? 33'(-d_hi) : 33'(d_hi);
	assign near_lo = ({3'b0, a_lo} <= thr8);
	assign near_hi = ({3'b0, a_hi} <= thr8);

	assign mv_e   = 36'(move_dist);
	assign half_e = $signed({6'b0, half});
	assign lo_dn  = slmb_pkg::sat32(36'(lo) - mv_e);
	assign hi_dn  = slmb_pkg::sat32(36'(hi) - mv_e);
	assign lo_up  = slmb_pkg::sat32(36'(lo) + mv_e);
	assign hi_up  = slmb_pkg::sat32(36'(hi) + mv_e);
	assign p_lo   = slmb_pkg::sat32(36'(pos) - half_e);
	assign p_hi   = slmb_pkg::sat32(36'(pos) + half_e);

	always_comb begin
		res.move   = !first && (near_lo || near_hi);
		res.down   = near_lo;
		res.rm_val = near_lo ? hi_dn : lo_up;
		if (first) begin
			res.new_lo = p_lo;
			res.new_hi = p_hi;
		end else if (near_lo) begin
			res.new_lo = lo_dn;
			res.new_hi = hi_dn;
		end else if (near_hi) begin
			res.new_lo = lo_up;
			res.new_hi = hi_up;
		end else begin
			res.new_lo = lo;
			res.new_hi = hi;
		end
	end

endmodule

// File: rtl/core/slmb_merge.sv
// Merge stage: holds one item's lane results and sends them out in order.
`timescale 1ns / 1ps

module slmb_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic signed [slmb_pkg::POS_W-1:0]   old_lo [slmb_pkg::NAXES],
	input  logic signed [slmb_pkg::POS_W-1:0]   old_hi [slmb_pkg::NAXES],
	input  slmb_pkg::lane_res_t                 res [slmb_pkg::NAXES],
	output logic                                can_load,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                kind,
	output logic signed [slmb_pkg::POS_W-1:0]   min_x,
	output logic signed [slmb_pkg::POS_W-1:0]   min_y,
	output logic signed [slmb_pkg::POS_W-1:0]   min_z,
	output logic signed [slmb_pkg::POS_W-1:0]   max_x,
	output logic signed [slmb_pkg::POS_W-1:0]   max_y,
	output logic signed [slmb_pkg::POS_W-1:0]   max_z,
	output logic                                last
);

	logic                               valid_q;
	logic [3:0]                         pend_q;
	logic [2:0]                         down_q;
	logic signed [slmb_pkg::POS_W-1:0]  old_lo_q [slmb_pkg::NAXES];
	logic signed [slmb_pkg::POS_W-1:0]  old_hi_q [slmb_pkg::NAXES];
	logic signed [slmb_pkg::POS_W-1:0]  new_lo_q [slmb_pkg::NAXES];
	logic signed [slmb_pkg::POS_W-1:0]  new_hi_q [slmb_pkg::NAXES];
	logic signed [slmb_pkg::POS_W-1:0]  rm_q [slmb_pkg::NAXES];

	logic [2:0]                         sel;
	logic                               cur_rm;
	logic                               fire;
	logic signed [slmb_pkg::POS_W-1:0]  lo_o [slmb_pkg::NAXES];
	logic signed [slmb_pkg::POS_W-1:0]  hi_o [slmb_pkg::NAXES];

	assign sel      = pend_q[2:0] & ~(pend_q[2:0] - 3'd1);
	assign cur_rm   = |pend_q[2:0];
	assign fire     = valid_q && !out_stall;
	assign can_load = !valid_q || (fire && !cur_rm);

	always_comb begin
		for (int j = 0; j < slmb_pkg::NAXES; j++) begin
			if (!cur_rm) begin
				lo_o[j] = new_lo_q[j];
				hi_o[j] = new_hi_q[j];
			end else begin
				lo_o[j] = (sel[j] && down_q[j]) ? rm_q[j] : old_lo_q[j];
				hi_o[j] = (sel[j] && !down_q[j]) ? rm_q[j] : old_hi_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= '0;
			down_q  <= '0;
			for (int j = 0; j < slmb_pkg::NAXES; j++) begin
				old_lo_q[j] <= '0;
				old_hi_q[j] <= '0;
				new_lo_q[j] <= '0;
				new_hi_q[j] <= '0;
				rm_q[j]     <= '0;
			end
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				pend_q  <= {1'b1, res[2].move, res[1].move, res[0].move};
				down_q  <= {res[2].down, res[1].down, res[0].down};
				for (int j = 0; j < slmb_pkg::NAXES; j++) begin
					old_lo_q[j] <= old_lo[j];
					old_hi_q[j] <= old_hi[j];
					new_lo_q[j] <= res[j].new_lo;
					new_hi_q[j] <= res[j].new_hi;
					rm_q[j]     <= res[j].rm_val;
				end
			end else if (fire) begin
				if (cur_rm) begin
					pend_q <= pend_q & (pend_q - 4'd1);
				end else begin
					valid_q <= 1'b0;
					pend_q  <= '0;
				end
			end
		end
	end

	assign out_valid = valid_q;
	assign kind      = cur_rm;
	assign last      = !cur_rm;
	assign min_x     = lo_o[0];
	assign min_y     = lo_o[1];
	assign min_z     = lo_o[2];
	assign max_x     = hi_o[0];
	assign max_y     = hi_o[1];
	assign max_z     = hi_o[2];

endmodule

// File: rtl/core/slmb_checker.sv
// Port-level checks of the sliding local map box and their binding.
`timescale 1ns / 1ps

module slmb_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                kind,
	input logic signed [slmb_pkg::POS_W-1:0]   min_x,
	input logic signed [slmb_pkg::POS_W-1:0]   max_x,
	input logic                                last
);

	// A stalled result stays on the port unchanged (checked on kind, last, min_x and max_x).
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last)
			&& $stable(min_x) && $stable(max_x))
		else $error("stalled result changed");

	// Only the current box closes an item, and it is never a removal box.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last != kind))
		else $error("last and kind disagree");

	// A removal box is always followed by more results of the same item.
	a_rm_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("item ended without its current box");

	// Nothing is offered while reset is held.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

endmodule

bind sliding_local_map_box slmb_checker u_slmb_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the sliding local map box: random and edge-case positions.
`timescale 1ns / 1ps

module testbench;

	localparam logic KIND_CURRENT = 1'b0;
	localparam logic KIND_REMOVE  = 1'b1;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	typedef logic signed [slmb_pkg::POS_W-1:0] coord_t;
	typedef coord_t corners_t [3];
	typedef logic [slmb_pkg::CFG_W-1:0] cfg_t;
	typedef logic [slmb_pkg::MR_W-1:0] ratio_t;

	typedef struct packed {
		logic   kind;
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
		logic   last;
	} map_box_t;

	typedef enum {
		AIM_CENTER,
		AIM_LOW_IN,
		AIM_LOW_OUT,
		AIM_HIGH_IN,
		AIM_HIGH_OUT,
		AIM_NEAR_LOW,
		AIM_NEAR_HIGH,
		AIM_INSIDE,
		AIM_ANY
	} aim_t;

	// Tracks the map cube and the registers, and holds the boxes the block owes us.
	class box_tracker;
		cfg_t        side_q;
		cfg_t        range_q;
		ratio_t      ratio_q;
		coord_t      lo_q [3];
		coord_t      hi_q [3];
		bit          placed;
		map_box_t    expected_boxes [$];
		int unsigned errors;

		function new();
			side_q = slmb_pkg::CUBE_SIDE_RST;
			range_q = slmb_pkg::DETECT_RANGE_RST;
			ratio_q = slmb_pkg::MOVE_RATIO_RST;
			for (int i = 0; i < 3; i++) begin
				lo_q[i] = '0;
				hi_q[i] = '0;
			end
			placed = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, cfg_t val);
			case (idx)
				slmb_pkg::CFG_CUBE_SIDE: begin
					side_q = val;
				end
				slmb_pkg::CFG_DETECT_RANGE: begin
					range_q = val;
				end
				slmb_pkg::CFG_MOVE_RATIO: begin
					ratio_q = val[slmb_pkg::MR_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function coord_t clip(longint v);
			if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
			if (v < -64'sd2147483648) return 32'sh8000_0000;
			return coord_t'(v);
		endfunction

		function longint floor_div(longint a, longint d);
			longint q;
			q = a / d;
			if ((a % d) != 0 && a < 0) q = q - 1;
			return q;
		endfunction

		function longint threshold();
			return longint'(range_q) * longint'(ratio_q);
		endfunction

		function longint move_step();
			longint a;
			longint b;
			longint m;
			a = floor_div((longint'(side_q) * 256 - 2 * threshold()) * 9, 20);
			b = longint'(range_q) * (longint'(ratio_q) - 256);
			m = (a > b) ? a : b;
			return floor_div(m + 128, 256);
		endfunction

		function map_box_t make_box(logic k, corners_t lo, corners_t hi, logic l);
			map_box_t r;
			r.kind = k;
			r.min_x = lo[0];
			r.min_y = lo[1];
			r.min_z = lo[2];
			r.max_x = hi[0];
			r.max_y = hi[1];
			r.max_z = hi[2];
			r.last = l;
			return r;
		endfunction

		function void owe_box(map_box_t b);
			expected_boxes = {expected_boxes, b};
		endfunction

		function void take_position(coord_t px, coord_t py, coord_t pz);
			longint   p [3];
			longint   half;
			longint   thr;
			longint   mv;
			longint   d_lo;
			longint   d_hi;
			corners_t nlo;
			corners_t nhi;
			corners_t rlo;
			corners_t rhi;
			p[0] = px;
			p[1] = py;
			p[2] = pz;
			if (!placed) begin
				half = longint'(side_q >> 1);
				for (int i = 0; i < 3; i++) begin
					lo_q[i] = clip(p[i] - half);
					hi_q[i] = clip(p[i] + half);
				end
				placed = 1'b1;
				owe_box(make_box(KIND_CURRENT, lo_q, hi_q, 1'b1));
				return;
			end
			thr = threshold();
			mv = move_step();
			nlo = lo_q;
			nhi = hi_q;
			for (int i = 0; i < 3; i++) begin
				d_lo = p[i] - longint'(lo_q[i]);
				d_hi = p[i] - longint'(hi_q[i]);
				if (d_lo < 0) d_lo = -d_lo;
				if (d_hi < 0) d_hi = -d_hi;
				rlo = lo_q;
				rhi = hi_q;
				// The low face wins when the position is near both.
				if (d_lo * 256 <= thr) begin
					nlo[i] = clip(longint'(lo_q[i]) - mv);
					nhi[i] = clip(longint'(hi_q[i]) - mv);
					rlo[i] = clip(longint'(hi_q[i]) - mv);
					owe_box(make_box(KIND_REMOVE, rlo, rhi, 1'b0));
				end else if (d_hi * 256 <= thr) begin
					nlo[i] = clip(longint'(lo_q[i]) + mv);
					nhi[i] = clip(longint'(hi_q[i]) + mv);
					rhi[i] = clip(longint'(lo_q[i]) + mv);
					owe_box(make_box(KIND_REMOVE, rlo, rhi, 1'b0));
				end
			end
			lo_q = nlo;
			hi_q = nhi;
			owe_box(make_box(KIND_CURRENT, lo_q, hi_q, 1'b1));
		endfunction

		function void check_field(string name, longint want, longint got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void compare_box(map_box_t got);
			map_box_t want;
			if (expected_boxes.size() == 0) begin
				errors++;
				$display("%0t: unexpected box: expected nothing, got kind %0d (%0d %0d %0d)",
					$time, got.kind, got.min_x, got.min_y, got.min_z);
				return;
			end
			want = expected_boxes[0];
			expected_boxes.delete(0);
			check_field("kind", want.kind, got.kind);
			check_field("min_x", want.min_x, got.min_x);
			check_field("min_y", want.min_y, got.min_y);
			check_field("min_z", want.min_z, got.min_z);
			check_field("max_x", want.max_x, got.max_x);
			check_field("max_y", want.max_y, got.max_y);
			check_field("max_z", want.max_z, got.max_z);
			check_field("last", want.last, got.last);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	coord_t     pos_x;
	coord_t     pos_y;
	coord_t     pos_z;
	logic       out_valid;
	logic       out_stall;
	logic       kind;
	coord_t     min_x;
	coord_t     min_y;
	coord_t     min_z;
	coord_t     max_x;
	coord_t     max_y;
	coord_t     max_z;
	logic       last;
	logic       cfg_we;
	logic [1:0] cfg_index;
	cfg_t       cfg_data;

	int         hold_requests;
	bit         eager;
	box_tracker sb = new();

	sliding_local_map_box dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.min_x     (min_x),
		.min_y     (min_y),
		.min_z     (min_z),
		.max_x     (max_x),
		.max_y     (max_y),
		.max_z     (max_z),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

	// Result side: checks every accepted box and stalls at random.
	initial begin
		int       run_left;
		int       hold_left;
		int       holds_done;
		int       r;
		bit       run_stall;
		map_box_t got;
		run_left = 0;
		hold_left = 0;
		holds_done = 0;
		run_stall = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.kind = kind;
				got.min_x = min_x;
				got.min_y = min_y;
				got.min_z = min_z;
				got.max_x = max_x;
				got.max_y = max_y;
				got.max_z = max_z;
				got.last = last;
				sb.compare_box(got);
			end
			if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					r = $urandom_range(0, 99);
					if (r < 45) begin
						run_stall = 1'b0;
						run_left = $urandom_range(1, 24);
					end else if (r < 92) begin
						run_stall = 1'b1;
						run_left = $urandom_range(1, 3);
					end else begin
						run_stall = 1'b1;
						run_left = $urandom_range(8, 40);
					end
				end
				run_left--;
				out_stall <= run_stall;
			end
		end
	end

	function automatic longint draw_upto(longint w);
		longint unsigned r;
		if (w <= 0) return 0;
		r = {$urandom, $urandom};
		return longint'(r % (longint'(w) + 1));
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic aim_t pick_aim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return AIM_NEAR_LOW;
		if (r < 50) return AIM_NEAR_HIGH;
		if (r < 70) return AIM_INSIDE;
		if (r < 78) return AIM_LOW_IN;
		if (r < 84) return AIM_LOW_OUT;
		if (r < 88) return AIM_HIGH_IN;
		if (r < 92) return AIM_HIGH_OUT;
		if (r < 95) return AIM_CENTER;
		return AIM_ANY;
	endfunction

	// Places one coordinate relative to the current cube and the edge threshold.
	function automatic coord_t aim_at(int axis, aim_t aim);
		longint lo;
		longint hi;
		longint t;
		longint v;
		lo = sb.lo_q[axis];
		hi = sb.hi_q[axis];
		t = sb.threshold() / 256;
		case (aim)
			AIM_CENTER: begin
				v = (lo + hi) >>> 1;
			end
			AIM_LOW_IN: begin
				v = lo + t;
			end
			AIM_LOW_OUT: begin
				v = lo + t + 1;
			end
			AIM_HIGH_IN: begin
				v = hi - t;
			end
			AIM_HIGH_OUT: begin
				v = hi - t - 1;
			end
			AIM_NEAR_LOW: begin
				v = lo - t - 8 + draw_upto(2 * t + 16);
			end
			AIM_NEAR_HIGH: begin
				v = hi - t - 8 + draw_upto(2 * t + 16);
			end
			AIM_INSIDE: begin
				v = lo + draw_upto(hi - lo);
			end
			default: begin
				v = longint'($signed($urandom));
			end
		endcase
		return sb.clip(v);
	endfunction

	task automatic pause_input(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic offer(coord_t x, coord_t y, coord_t z);
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		do @(posedge clk); while (in_stall);
		sb.take_position(x, y, z);
		pause_input(eager ? 0 : gap_len());
	endtask

	task automatic offer_aimed(aim_t ax, aim_t ay, aim_t az);
		offer(aim_at(0, ax), aim_at(1, ay), aim_at(2, az));
	endtask

	task automatic roam(int n);
		for (int k = 0; k < n; k++)
			offer_aimed(pick_aim(), pick_aim(), pick_aim());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_boxes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs(cfg_t side, cfg_t rng, ratio_t ratio);
		cfg_we <= 1'b1;
		cfg_index <= slmb_pkg::CFG_CUBE_SIDE;
		cfg_data <= side;
		@(posedge clk);
		sb.write_reg(slmb_pkg::CFG_CUBE_SIDE, side);
		cfg_index <= slmb_pkg::CFG_DETECT_RANGE;
		cfg_data <= rng;
		@(posedge clk);
		sb.write_reg(slmb_pkg::CFG_DETECT_RANGE, rng);
		cfg_index <= slmb_pkg::CFG_MOVE_RATIO;
		cfg_data <= cfg_t'(ratio);
		@(posedge clk);
		sb.write_reg(slmb_pkg::CFG_MOVE_RATIO, cfg_t'(ratio));
		cfg_we <= 1'b0;
	endtask

	initial begin
		cfg_t side;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		cfg_we <= 1'b0;
		cfg_index <= slmb_pkg::CFG_CUBE_SIDE;
		cfg_data <= '0;
		hold_requests <= 0;
		eager = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: the first item centers the cube, then faces of one axis and of several, then extreme positions.
		offer(32'sd0, 32'sd0, 32'sd0);
		offer_aimed(AIM_CENTER, AIM_CENTER, AIM_CENTER);
		offer_aimed(AIM_LOW_IN, AIM_CENTER, AIM_CENTER);
		offer_aimed(AIM_LOW_OUT, AIM_CENTER, AIM_CENTER);
		offer_aimed(AIM_CENTER, AIM_HIGH_IN, AIM_CENTER);
		offer_aimed(AIM_CENTER, AIM_CENTER, AIM_HIGH_OUT);
		offer_aimed(AIM_LOW_IN, AIM_HIGH_IN, AIM_LOW_IN);
		offer(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		offer(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
		offer(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0);

		// The result side holds off while items keep coming, so the block backs up.
		hold_requests <= hold_requests + 1;
		eager = 1'b1;
		roam(30);
		eager = 1'b0;
		roam(10);
		drain();

		// Largest cube side and detect range: every face is near and the corners saturate.
		load_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 13'd4096);
		offer_aimed(AIM_CENTER, AIM_CENTER, AIM_CENTER);
		offer_aimed(AIM_HIGH_IN, AIM_LOW_OUT, AIM_ANY);
		roam(12);
		drain();

		// Zero threshold and zero move: only a position on a face counts as near.
		load_regs(31'd0, 31'd0, 13'd257);
		offer_aimed(AIM_LOW_IN, AIM_HIGH_IN, AIM_CENTER);
		offer_aimed(AIM_LOW_OUT, AIM_HIGH_OUT, AIM_LOW_IN);
		roam(18);
		drain();

		// A ratio below one with a small cube gives a negative move.
		load_regs(31'd655360, 31'd6553600, 13'd128);
		offer_aimed(AIM_LOW_IN, AIM_HIGH_IN, AIM_CENTER);
		roam(20);
		drain();

		load_regs(31'h7FFF_FFFF, 31'd65536, 13'd0);
		roam(20);
		drain();

		load_regs(31'd655360, 31'd196608, 13'd384);
		roam(30);
		drain();

		for (int k = 0; k < 5; k++) begin
			side = cfg_t'($urandom_range(32'h0001_0000, 32'h0400_0000));
			load_regs(side, cfg_t'($urandom_range(0, side)),
				ratio_t'($urandom_range(257, 4096)));
			roam(24);
			drain();
		end

		if (sb.errors == 0 && sb.expected_boxes.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
